[rtl/core/mhh_pkg.sv]
// ----------------------------------------------------------------------------
// mhh_pkg
// Shared types, constants and the arctangent table for the hard-iron
// calibration and heading block.
// ----------------------------------------------------------------------------
package mhh_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int IDX_W        = $clog2(CORDIC_STEPS);

    // CORDIC vector width, angle accumulator width, wrapped angle width.
    localparam int CW = 49;
    localparam int ZW = 34;
    localparam int AW = 33;
    localparam int PW = AW + 9;

    localparam logic signed [15:0] LIMIT_INIT    = 16'sd32700;
    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1073741824);
    localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(64'sd2147483648);
    localparam logic signed [ZW-1:0] FULL_TURN    = ZW'(64'sd4294967296);
    localparam logic [PW-1:0]        DEG_PER_TURN = PW'(360);

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef enum logic [1:0] {
        CFG_CALIBRATE = 2'd0,
        CFG_OFFSET_X  = 2'd1,
        CFG_OFFSET_Y  = 2'd2,
        CFG_OFFSET_Z  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic              op;
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] corr_x;
        logic signed [15:0] corr_y;
        logic signed [15:0] corr_z;
        logic [8:0]         heading_deg;
        logic               valid_res;
    } out_item_t;

    typedef struct packed {
        logic              calibrate;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic signed [15:0] offset_z;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIMIT,
        ST_CORRECT,
        ST_PREROT,
        ST_ITER,
        ST_WRAP,
        ST_SCALE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             load_in;
        logic             limit;
        logic             correct;
        logic             prerot;
        logic             iter;
        logic             wrap;
        logic             scale;
        logic             push;
        logic [IDX_W-1:0] iter_idx;
    } cmd_t;

    typedef struct packed {
        logic skip;
    } stat_t;

    // Arctangent of 2^-i in binary angle units (2^32 per turn), rounded.
    function automatic logic [30:0] atan_entry(input logic [4:0] i);
        logic [30:0] r;
        case (i)
            5'd0:  r = 31'd536870912;
            5'd1:  r = 31'd316933406;
            5'd2:  r = 31'd167458907;
            5'd3:  r = 31'd85004756;
            5'd4:  r = 31'd42667331;
            5'd5:  r = 31'd21354465;
            5'd6:  r = 31'd10679838;
            5'd7:  r = 31'd5340245;
            5'd8:  r = 31'd2670163;
            5'd9:  r = 31'd1335087;
            5'd10: r = 31'd667544;
            5'd11: r = 31'd333772;
            5'd12: r = 31'd166886;
            5'd13: r = 31'd83443;
            5'd14: r = 31'd41722;
            5'd15: r = 31'd20861;
            5'd16: r = 31'd10430;
            5'd17: r = 31'd5215;
            5'd18: r = 31'd2608;
            5'd19: r = 31'd1304;
            5'd20: r = 31'd652;
            5'd21: r = 31'd326;
            5'd22: r = 31'd163;
            5'd23: r = 31'd81;
            5'd24: r = 31'd41;
            5'd25: r = 31'd20;
            5'd26: r = 31'd10;
            5'd27: r = 31'd5;
            5'd28: r = 31'd3;
            5'd29: r = 31'd1;
            5'd30: r = 31'd1;
            default: r = 31'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/mhh_ctrl.sv]
// ----------------------------------------------------------------------------
// mhh_ctrl
// Sequencer for one transaction: limit update, offset correction, CORDIC
// iterations, angle scaling, and the output register handshake.
// ----------------------------------------------------------------------------
module mhh_ctrl
    import mhh_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] iter_reg, iter_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LIMIT;
                end
            end
            ST_LIMIT: begin
                state_next = stat.skip ? ST_DONE : ST_CORRECT;
            end
            ST_CORRECT: begin
                state_next = ST_PREROT;
            end
            ST_PREROT: begin
                iter_next  = '0;
                state_next = ST_ITER;
            end
            ST_ITER: begin
                if (iter_reg == IDX_W'(CORDIC_STEPS - 1)) begin
                    state_next = ST_WRAP;
                end else begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_WRAP: begin
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        cmd          = '0;
        cmd.iter_idx = iter_reg;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_LIMIT:   cmd.limit   = 1'b1;
            ST_CORRECT: cmd.correct = 1'b1;
            ST_PREROT:  cmd.prerot  = 1'b1;
            ST_ITER:    cmd.iter    = 1'b1;
            ST_WRAP:    cmd.wrap    = 1'b1;
            ST_SCALE:   cmd.scale   = 1'b1;
            ST_DONE:    cmd.push    = out_free;
            default:    cmd.push    = 1'b0;
        endcase
    end

    always_comb begin
        if (cmd.push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[rtl/core/mhh_datapath.sv]
// ----------------------------------------------------------------------------
// mhh_datapath
// Per-axis limit tracking, offset correction, a shared CORDIC stage run once
// per step, angle wrap and degree scaling, and the result register.
// ----------------------------------------------------------------------------
module mhh_datapath
    import mhh_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  s_data,
    input  cfg_t      cfg,
    input  cmd_t      cmd,
    output stat_t     stat,
    output out_item_t m_data
);

    in_item_t           item_reg;
    logic signed [15:0] low_reg  [3];
    logic signed [15:0] high_reg [3];
    logic signed [15:0] off_reg  [3];
    logic signed [15:0] corr_reg [3];
    logic               ok_reg;
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic               axis_reg;
    logic [AW-1:0]      ang_reg;
    logic [8:0]         head_reg;
    out_item_t          out_reg;

    logic signed [15:0] raw      [3];
    logic signed [15:0] setting  [3];
    logic signed [15:0] low_next [3];
    logic signed [15:0] high_next[3];
    logic signed [15:0] off_lim  [3];
    logic signed [15:0] mid      [3];
    logic signed [15:0] off_use  [3];
    logic signed [16:0] lim_sum  [3];
    logic               spread;
    logic               restart;

    assign raw[0]     = item_reg.mag_x;
    assign raw[1]     = item_reg.mag_y;
    assign raw[2]     = item_reg.mag_z;
    assign setting[0] = cfg.offset_x;
    assign setting[1] = cfg.offset_y;
    assign setting[2] = cfg.offset_z;
    assign restart    = (item_reg.op == OP_RESTART);

    // Limit update, or reload on a restart transaction.
    always_comb begin
        spread = 1'b1;
        for (int k = 0; k < 3; k++) begin
            low_next[k]  = low_reg[k];
            high_next[k] = high_reg[k];
            off_lim[k]   = off_reg[k];
            if (restart) begin
                if (cfg.calibrate) begin
                    low_next[k]  = LIMIT_INIT;
                    high_next[k] = -LIMIT_INIT;
                    off_lim[k]   = '0;
                end else begin
                    low_next[k]  = '0;
                    high_next[k] = '0;
                    off_lim[k]   = setting[k];
                end
            end else if (cfg.calibrate) begin
                if (raw[k] < low_reg[k]) begin
                    low_next[k] = raw[k];
                end
                if (raw[k] > high_reg[k]) begin
                    high_next[k] = raw[k];
                end
            end
            if (low_next[k] >= high_next[k]) begin
                spread = 1'b0;
            end
        end
    end

    assign stat.skip = restart || (cfg.calibrate && !spread);

    // Midpoint of the limits, truncated toward zero.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lim_sum[k] = 17'(low_reg[k]) + 17'(high_reg[k]);
            mid[k]     = 16'((lim_sum[k] + 17'(lim_sum[k][16])) >>> 1);
            off_use[k] = cfg.calibrate ? mid[k] : off_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                low_reg[k]  <= '0;
                high_reg[k] <= '0;
                off_reg[k]  <= '0;
            end
        end else if (cmd.limit) begin
            for (int k = 0; k < 3; k++) begin
                low_reg[k]  <= low_next[k];
                high_reg[k] <= high_next[k];
                off_reg[k]  <= off_lim[k];
            end
        end else if (cmd.correct) begin
            for (int k = 0; k < 3; k++) begin
                off_reg[k] <= off_use[k];
            end
        end
    end

    // CORDIC input: a = corr_x, b = -corr_y, both scaled by 2^30.
    logic signed [15:0]   a_val;
    logic signed [16:0]   b_val;
    logic signed [CW-1:0] ax, bx;
    logic signed [CW-1:0] x_init, y_init;
    logic signed [ZW-1:0] z_init;
    logic                 axis_init;

    always_comb begin
        a_val     = corr_reg[0];
        b_val     = -{corr_reg[1][15], corr_reg[1]};
        ax        = {{(CW - 46){a_val[15]}}, a_val, 30'b0};
        bx        = {{(CW - 47){b_val[16]}}, b_val, 30'b0};
        axis_init = (a_val == '0) || (b_val == '0);
        x_init    = bx;
        y_init    = ax;
        z_init    = '0;
        if (a_val == '0) begin
            z_init = b_val[16] ? HALF_TURN : '0;
        end else if (b_val == '0) begin
            z_init = (a_val > 0) ? QUARTER_TURN : -QUARTER_TURN;
        end else if (bx < 0) begin
            // Rotate into the right half plane first.
            if (ax > 0) begin
                x_init = ax;
                y_init = -bx;
                z_init = QUARTER_TURN;
            end else begin
                x_init = -ax;
                y_init = bx;
                z_init = -QUARTER_TURN;
            end
        end
    end

    // One vectoring step per cycle.
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] step_ang;

    always_comb begin
        dx       = y_reg >>> cmd.iter_idx;
        dy       = x_reg >>> cmd.iter_idx;
        step_ang = signed'(ZW'(atan_entry(5'(cmd.iter_idx))));
    end

    logic signed [ZW-1:0] z_wrapped;
    logic [PW-1:0]        prod;

    assign z_wrapped = (z_reg <= 0) ? z_reg + FULL_TURN : z_reg;
    assign prod      = PW'(ang_reg) * DEG_PER_TURN;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            item_reg <= s_data;
        end
        if (cmd.limit) begin
            ok_reg <= !stat.skip;
        end
        if (cmd.correct) begin
            for (int k = 0; k < 3; k++) begin
                corr_reg[k] <= raw[k] - off_use[k];
            end
        end
        if (cmd.prerot) begin
            x_reg    <= x_init;
            y_reg    <= y_init;
            z_reg    <= z_init;
            axis_reg <= axis_init;
        end
        if (cmd.iter && !axis_reg) begin
            if (y_reg > 0) begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + step_ang;
            end else begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - step_ang;
            end
        end
        if (cmd.wrap) begin
            ang_reg <= z_wrapped[AW-1:0];
        end
        if (cmd.scale) begin
            head_reg <= prod[AW+7 -: 9];
        end
        if (cmd.push) begin
            if (ok_reg) begin
                out_reg.corr_x      <= corr_reg[0];
                out_reg.corr_y      <= corr_reg[1];
                out_reg.corr_z      <= corr_reg[2];
                out_reg.heading_deg <= head_reg;
                out_reg.valid_res   <= 1'b1;
            end else begin
                out_reg <= '0;
            end
        end
    end

    assign m_data = out_reg;

endmodule

[rtl/core/magnetometer_hard_iron_heading.sv]
// ----------------------------------------------------------------------------
// magnetometer_hard_iron_heading
// Hard-iron min/max calibration of a three-axis magnetometer sample with a
// CORDIC heading in whole degrees.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one transaction per raw sample (op = sample)
//   or a restart of the limits and offsets (op = restart). m_valid/m_ready/
//   m_data return exactly one result transaction for each input transaction.
//   The configuration port (cfg_wr_en, cfg_index, cfg_wdata) writes the mode or one of
//   the three saved offsets, selected by cfg_index; write it only while idle.
//   A new sample is accepted only after the previous one has been pushed to the
//   output register; the CORDIC step loop runs one step per cycle on a single
//   shift-add unit. A restart or an unspread calibration sample skips the
//   correction and the CORDIC steps and pushes an all-zero result.
//   The result sits in an output register; a new sample is accepted while it
//   waits, and processing stalls before the next write to that register
//   until the receiver takes the pending result.
//   Reset clears the mode, the offset settings, the limits and the stored
//   offsets, and empties the output register.
// ----------------------------------------------------------------------------
module magnetometer_hard_iron_heading
    import mhh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CALIBRATE: cfg_reg.calibrate <= cfg_wdata[0];
                CFG_OFFSET_X:  cfg_reg.offset_x  <= cfg_wdata;
                CFG_OFFSET_Y:  cfg_reg.offset_y  <= cfg_wdata;
                CFG_OFFSET_Z:  cfg_reg.offset_z  <= cfg_wdata;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    mhh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mhh_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule
